// File: hdl/drba_pkg.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access package
// Shared types, codes and field widths of the row buffer access core.
// ----------------------------------------------------------------------------
package drba_pkg;

	localparam int DELAY_W = 10;
	localparam int LIMIT_W = 17;
	localparam int LAT_W   = 12;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_RANGE      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_HIT        = 2'd0,
		KIND_EMPTY      = 2'd1,
		KIND_CLEAN_MISS = 2'd2,
		KIND_DIRTY      = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_DELAY    = 2'd0,
		CFG_COLUMN_DELAY = 2'd1,
		CFG_MEM_LIMIT    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DELAY_W-1:0] row_delay;
		logic [DELAY_W-1:0] column_delay;
		logic [LIMIT_W-1:0] mem_limit;
	} cfg_t;

	typedef struct packed {
		logic              is_store;
		status_t           status;
		logic [WORD_W-1:0] store_data;
	} cmd_t;

endpackage

// File: hdl/drba_front.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access front end
// Accepts commands, checks range and alignment, splits the address into row
// and word index, and hands each item to the queue.
// ----------------------------------------------------------------------------
module drba_front import drba_pkg::*; #(
	parameter int NUM_ROWS  = 64,
	parameter int ROW_BYTES = 1024,
	parameter int ROW_W     = 6,
	parameter int WIDX_W    = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              clearing,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [WORD_W-1:0] byte_address,
	input  logic [WORD_W-1:0] store_data,
	input  logic              queue_full,
	output logic              push,
	output cmd_t              cmd,
	output logic [ROW_W-1:0]  row,
	output logic [WIDX_W-1:0] widx
);

	localparam int MEM_BYTES = NUM_ROWS * ROW_BYTES;
	localparam int MEM_WORDS = MEM_BYTES / 4;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int ROW_L     = $clog2(ROW_BYTES);
	localparam int SH        = ADDR_W + ROW_L;
	localparam int RECIP_W   = ADDR_W + 1;
	localparam int PROD_W    = ADDR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SH) + 64'(ROW_BYTES) - 64'd1) / 64'(ROW_BYTES));

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [WIDX_W-1:0] widx_s1;

	logic              accept;
	logic              negative;
	logic              above;
	status_t           status_c;
	logic [PROD_W-1:0] prod;

	assign busy   = clearing || (valid_s1 && queue_full);
	assign accept = start && !busy;
	assign push   = valid_s1 && !queue_full;

	always_comb begin
		negative = byte_address[WORD_W-1];
		above    = !negative && ((byte_address >= WORD_W'(cfg.mem_limit)) ||
			(byte_address >= WORD_W'(MEM_BYTES)));
		if (above) begin
			status_c = ST_RANGE;
		end else if (byte_address[1:0] != 2'b00) begin
			status_c = ST_MISALIGNED;
		end else if (negative || (byte_address[WORD_W-1:2] >= (WORD_W-2)'(MEM_WORDS))) begin
			status_c = ST_RANGE;
		end else begin
			status_c = ST_OK;
		end
		prod = PROD_W'(byte_address[ADDR_W-1:0]) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_store   <= operation;
			cmd_s1.status     <= status_c;
			cmd_s1.store_data <= store_data;
			row_s1            <= prod[SH +: ROW_W];
			widx_s1           <= byte_address[WIDX_W+1:2];
		end
	end

	assign cmd  = cmd_s1;
	assign row  = row_s1;
	assign widx = widx_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && queue_full |=> valid_s1 && $stable(cmd_s1))
		else $error("front item lost while the queue was full");

	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("item accepted during the memory clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !$past(accept) && !valid_s1 |=> valid_s1)
		else $error("accepted item did not reach the front register");

endmodule

// File: hdl/drba_queue.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access queue
// Two-entry queue that decouples the front end from the access engine.
// ----------------------------------------------------------------------------
module drba_queue import drba_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/drba_back.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access engine
// Holds the word memory and the open row buffer, classifies each access
// against the buffer, performs the load or store and reports the result.
// ----------------------------------------------------------------------------
module drba_back import drba_pkg::*; #(
	parameter int NUM_ROWS  = 64,
	parameter int ROW_BYTES = 1024,
	parameter int ROW_W     = 6,
	parameter int WIDX_W    = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	output logic              clearing,
	input  logic              queue_empty,
	output logic              pop,
	input  cmd_t              cmd,
	input  logic [ROW_W-1:0]  row,
	input  logic [WIDX_W-1:0] widx,
	output logic              done,
	output logic [WORD_W-1:0] load_data,
	output logic [1:0]        status,
	output logic [1:0]        access_kind,
	output logic [LAT_W-1:0]  latency_cycles,
	output logic [ROW_W-1:0]  writeback_row,
	output logic [CNT_W-1:0]  buffer_updates
);

	localparam int MEM_WORDS = NUM_ROWS * ROW_BYTES / 4;

	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [WORD_W-1:0] rdata_q;

	logic              clearing_q;
	logic [WIDX_W-1:0] clr_idx_q;

	logic [ROW_W-1:0]  open_row_q;
	logic              open_valid_q;
	logic              dirty_q;
	logic [CNT_W-1:0]  count_q;

	logic              done_s2;
	logic              load_sel_s2;
	status_t           status_s2;
	kind_t             kind_s2;
	logic [LAT_W-1:0]  latency_s2;
	logic [ROW_W-1:0]  wb_row_s2;
	logic [CNT_W-1:0]  updates_s2;

	logic              ok;
	logic              hit;
	kind_t             kind_c;
	logic [LAT_W-1:0]  latency_c;
	logic [ROW_W-1:0]  wb_row_c;
	logic [1:0]        inc_c;
	logic [CNT_W:0]    sum_c;
	logic [CNT_W-1:0]  count_c;
	logic              mem_we;
	logic [WIDX_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	assign clearing = clearing_q;
	assign pop      = !queue_empty && !clearing_q;

	always_comb begin
		ok        = (cmd.status == ST_OK);
		hit       = open_valid_q && (row == open_row_q);
		kind_c    = KIND_HIT;
		latency_c = '0;
		wb_row_c  = '0;
		inc_c     = 2'd0;
		if (ok) begin
			if (hit) begin
				kind_c    = KIND_HIT;
				latency_c = LAT_W'(cfg.column_delay);
			end else if (!open_valid_q) begin
				kind_c    = KIND_EMPTY;
				latency_c = LAT_W'(cfg.row_delay) + LAT_W'(cfg.column_delay);
			end else if (!dirty_q) begin
				kind_c    = KIND_CLEAN_MISS;
				latency_c = LAT_W'(cfg.row_delay) + LAT_W'(cfg.column_delay);
			end else begin
				kind_c    = KIND_DIRTY;
				wb_row_c  = open_row_q;
				latency_c = LAT_W'({cfg.row_delay, 1'b0}) + LAT_W'(cfg.column_delay);
			end
			inc_c = 2'(!hit) + 2'(cmd.is_store);
		end
		sum_c   = {1'b0, count_q} + (CNT_W+1)'(inc_c);
		count_c = sum_c[CNT_W] ? '1 : sum_c[CNT_W-1:0];
		mem_we    = clearing_q || (pop && ok && cmd.is_store);
		mem_waddr = clearing_q ? clr_idx_q : widx;
		mem_wdata = clearing_q ? '0 : cmd.store_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + WIDX_W'(1);
			if (clr_idx_q == WIDX_W'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_row_q   <= '0;
			open_valid_q <= 1'b0;
			dirty_q      <= 1'b0;
			count_q      <= '0;
			done_s2      <= 1'b0;
		end else begin
			done_s2 <= pop;
			if (pop && ok) begin
				count_q <= count_c;
				if (!hit) begin
					open_row_q   <= row;
					open_valid_q <= 1'b1;
				end
				if (cmd.is_store) begin
					dirty_q <= 1'b1;
				end else if (!hit) begin
					dirty_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			load_sel_s2 <= ok && !cmd.is_store;
			status_s2   <= cmd.status;
			kind_s2     <= kind_c;
			latency_s2  <= latency_c;
			wb_row_s2   <= wb_row_c;
			updates_s2  <= ok ? count_c : count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[widx];
	end

	assign done           = done_s2;
	assign load_data      = load_sel_s2 ? rdata_q : '0;
	assign status         = status_s2;
	assign access_kind    = kind_s2;
	assign latency_cycles = latency_s2;
	assign writeback_row  = wb_row_s2;
	assign buffer_updates = updates_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 && (status_s2 != ST_OK) |->
			(kind_s2 == KIND_HIT) && (latency_s2 == '0) && (wb_row_s2 == '0) && !load_sel_s2)
		else $error("flagged access reported buffer activity");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 && (kind_s2 != KIND_DIRTY) |-> (wb_row_s2 == '0))
		else $error("writeback row reported without a dirty conflict");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q >= $past(count_q)))
		else $error("update count went backwards");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && ok && !hit && !cmd.is_store |=> open_valid_q && !dirty_q)
		else $error("activation by a load left the buffer dirty");

endmodule

// File: hdl/dram_row_buffer_access_core.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access core
// Word loads and stores through a single open-row buffer, with hit, empty,
// clean miss and dirty conflict classification and reported latency.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  command   start / busy          operation, byte_address, store_data
//  result    done (one cycle)      load_data, status, access_kind,
//                                  latency_cycles, writeback_row, buffer_updates
//  config    cfg_we                cfg_index, cfg_wdata
//
// One item per cycle is sustained outside the memory clear; each item passes the
// front register, the queue and the engine, whose memory read is registered along
// with the result strobe. After reset the word memory is cleared one word a cycle,
// all NUM_ROWS*ROW_BYTES/4 words (16384 by default), with busy held high;
// configuration writes go on. Busy also rises when the front register holds an
// item and the two-entry queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
module dram_row_buffer_access_core import drba_pkg::*; #(
	parameter int NUM_ROWS  = 64,
	parameter int ROW_BYTES = 1024,
	localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  logic signed [31:0]   byte_address,
	input  logic signed [31:0]   store_data,
	output logic                 done,
	output logic signed [31:0]   load_data,
	output logic [1:0]           status,
	output logic [1:0]           access_kind,
	output logic [LAT_W-1:0]     latency_cycles,
	output logic [ROW_W-1:0]     writeback_row,
	output logic [CNT_W-1:0]     buffer_updates,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_wdata
);

	localparam int MEM_WORDS = NUM_ROWS * ROW_BYTES / 4;
	localparam int WIDX_W    = $clog2(MEM_WORDS);
	localparam int QW        = $bits(cmd_t) + ROW_W + WIDX_W;

	cfg_t              cfg_q;
	logic              clearing;
	logic              queue_full;
	logic              queue_empty;
	logic              push;
	logic              pop;
	cmd_t              front_cmd;
	logic [ROW_W-1:0]  front_row;
	logic [WIDX_W-1:0] front_widx;
	logic [QW-1:0]     queue_out;
	cmd_t              back_cmd;
	logic [ROW_W-1:0]  back_row;
	logic [WIDX_W-1:0] back_widx;
	logic [WORD_W-1:0] load_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_delay    <= DELAY_W'(10);
			cfg_q.column_delay <= DELAY_W'(2);
			cfg_q.mem_limit    <= LIMIT_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_DELAY:    cfg_q.row_delay    <= cfg_wdata[DELAY_W-1:0];
				CFG_COLUMN_DELAY: cfg_q.column_delay <= cfg_wdata[DELAY_W-1:0];
				CFG_MEM_LIMIT:    cfg_q.mem_limit    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	drba_front #(
		.NUM_ROWS  (NUM_ROWS),
		.ROW_BYTES (ROW_BYTES),
		.ROW_W     (ROW_W),
		.WIDX_W    (WIDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.clearing     (clearing),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.byte_address (byte_address),
		.store_data   (store_data),
		.queue_full   (queue_full),
		.push         (push),
		.cmd          (front_cmd),
		.row          (front_row),
		.widx         (front_widx)
	);

	drba_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_cmd, front_row, front_widx}),
		.pop       (pop),
		.pop_data  (queue_out),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	assign back_cmd  = queue_out[QW-1 -: $bits(cmd_t)];
	assign back_row  = queue_out[WIDX_W +: ROW_W];
	assign back_widx = queue_out[WIDX_W-1:0];

	drba_back #(
		.NUM_ROWS  (NUM_ROWS),
		.ROW_BYTES (ROW_BYTES),
		.ROW_W     (ROW_W),
		.WIDX_W    (WIDX_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.clearing       (clearing),
		.queue_empty    (queue_empty),
		.pop            (pop),
		.cmd            (back_cmd),
		.row            (back_row),
		.widx           (back_widx),
		.done           (done),
		.load_data      (load_word),
		.status         (status),
		.access_kind    (access_kind),
		.latency_cycles (latency_cycles),
		.writeback_row  (writeback_row),
		.buffer_updates (buffer_updates)
	);

	assign load_data = load_word;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// DRAM row buffer access core testbench
// Drives word loads and stores through the command port, predicts every
// result from a behavioral copy of the memory and the open-row buffer, and
// checks each result field in order. Directed accesses cover the buffer
// states, the address flags and the register extremes; random phases with
// changing register settings follow.
// ----------------------------------------------------------------------------
module tb_top;
	import drba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ROWS   = 64;
	localparam int ROW_BYTES  = 1024;
	localparam int ROW_W      = $clog2(NUM_ROWS);
	localparam int MEM_WORDS  = NUM_ROWS * ROW_BYTES / 4;
	localparam logic [31:0] MEM_BYTES = NUM_ROWS * ROW_BYTES;
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;
	localparam int IDLE_LIMIT = 100000;

	typedef struct packed {
		logic [WORD_W-1:0] load_data;
		status_t           status;
		kind_t             kind;
		logic [LAT_W-1:0]  latency;
		logic [ROW_W-1:0]  wb_row;
		logic [CNT_W-1:0]  updates;
	} access_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 operation = 1'b0;
	logic signed [31:0]   byte_address = '0;
	logic signed [31:0]   store_data = '0;
	logic                 done;
	logic signed [31:0]   load_data;
	logic [1:0]           status;
	logic [1:0]           access_kind;
	logic [LAT_W-1:0]     latency_cycles;
	logic [ROW_W-1:0]     writeback_row;
	logic [CNT_W-1:0]     buffer_updates;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;

	// Predicted state of the block.
	logic [WORD_W-1:0]  word_mem [MEM_WORDS];
	logic [ROW_W-1:0]   open_row = '0;
	logic               row_valid = 1'b0;
	logic               row_dirty = 1'b0;
	logic [CNT_W-1:0]   update_count = '0;
	logic [DELAY_W-1:0] row_delay = 10'd10;
	logic [DELAY_W-1:0] col_delay = 10'd2;
	logic [LIMIT_W-1:0] mem_limit = 17'd65536;

	access_result_t pending_results[$];
	int unsigned    hot_rows[3];
	int             errors = 0;

	dram_row_buffer_access_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.byte_address(byte_address),
		.store_data(store_data),
		.done(done),
		.load_data(load_data),
		.status(status),
		.access_kind(access_kind),
		.latency_cycles(latency_cycles),
		.writeback_row(writeback_row),
		.buffer_updates(buffer_updates),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic void bump_updates();
		if (update_count != '1) begin
			update_count++;
		end
	endfunction

	function automatic access_result_t predict_access(input logic op, input logic [31:0] addr,
			input logic [31:0] data);
		access_result_t r;
		logic [ROW_W-1:0] row;
		r = '0;
		if (!addr[31] && (addr >= {15'd0, mem_limit} || addr >= MEM_BYTES)) begin
			r.status = ST_RANGE;
		end else if (addr[1:0] != 2'd0) begin
			r.status = ST_MISALIGNED;
		end else if (addr[31]) begin
			r.status = ST_RANGE;
		end else begin
			row = addr[15:10];
			if (row_valid && row == open_row) begin
				r.kind = KIND_HIT;
				r.latency = LAT_W'(col_delay);
			end else begin
				if (!row_valid) begin
					r.kind = KIND_EMPTY;
					r.latency = LAT_W'(row_delay) + LAT_W'(col_delay);
				end else if (!row_dirty) begin
					r.kind = KIND_CLEAN_MISS;
					r.latency = LAT_W'(row_delay) + LAT_W'(col_delay);
				end else begin
					r.kind = KIND_DIRTY;
					r.wb_row = open_row;
					r.latency = LAT_W'(row_delay) * LAT_W'(2) + LAT_W'(col_delay);
				end
				bump_updates();
				open_row = row;
				row_valid = 1'b1;
				row_dirty = 1'b0;
			end
			if (op == OP_STORE) begin
				word_mem[addr[15:2]] = data;
				row_dirty = 1'b1;
				bump_updates();
			end else begin
				r.load_data = word_mem[addr[15:2]];
			end
		end
		r.updates = update_count;
		return r;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return DELAY_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [31:0] pick_address(input int unsigned span);
		int unsigned r;
		logic [31:0] a;
		r = $urandom_range(0, 99);
		if (span < 4 || r >= 92) begin
			a = $urandom;
		end else if (r >= 88) begin
			a = span - 4 + $urandom_range(0, 7);
		end else if (r >= 78) begin
			a = $urandom_range(0, span - 1);
			if (a[1:0] == 2'd0) begin
				a[1:0] = 2'($urandom_range(1, 3));
			end
		end else if (r >= 68) begin
			a = $urandom_range(0, span - 1) & ~32'd3;
		end else begin
			a = hot_rows[$urandom_range(0, 2)] * ROW_BYTES + $urandom_range(0, 255) * 4;
			if (a >= span) begin
				a = $urandom_range(0, span - 1) & ~32'd3;
			end
		end
		return a;
	endfunction

	task automatic send_access(input logic op, input logic [31:0] addr, input logic [31:0] data,
			input bit may_idle);
		int gap;
		access_result_t expected;
		start <= 1'b1;
		operation <= op;
		byte_address <= addr;
		store_data <= data;
		do @(posedge clk); while (busy);
		expected = predict_access(op, addr, data);
		pending_results.insert(pending_results.size(), expected);
		gap = may_idle ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [LIMIT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ROW_DELAY: row_delay = value[DELAY_W-1:0];
			CFG_COLUMN_DELAY: col_delay = value[DELAY_W-1:0];
			CFG_MEM_LIMIT: mem_limit = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_default_timing();
		send_access(OP_LOAD, 32'h0000_0000, 32'h1234_5678, 1'b0);
		send_access(OP_STORE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		send_access(OP_LOAD, 32'h0000_0000, 32'h0, 1'b1);
		send_access(OP_STORE, 32'h0000_1404, 32'h8000_0000, 1'b1);
		send_access(OP_LOAD, 32'h0000_1404, 32'h0, 1'b0);
		send_access(OP_LOAD, 32'h0000_1C00, 32'h0, 1'b1);
		send_access(OP_LOAD, 32'h0000_2400, 32'h0, 1'b0);
		send_access(OP_STORE, 32'h0000_FFFC, 32'h7FFF_FFFF, 1'b1);
		send_access(OP_LOAD, 32'h0000_FFFC, 32'h0, 1'b0);
		send_access(OP_LOAD, 32'h0000_0001, 32'h0, 1'b0);
		send_access(OP_STORE, 32'h0000_0002, 32'h5555_AAAA, 1'b1);
		send_access(OP_LOAD, 32'h0000_0003, 32'h0, 1'b0);
		send_access(OP_LOAD, 32'h0001_0000, 32'h0, 1'b0);
		send_access(OP_STORE, 32'h0000_FFFF, 32'hDEAD_BEEF, 1'b1);
		send_access(OP_LOAD, 32'hFFFF_FFFC, 32'h0, 1'b0);
		send_access(OP_STORE, 32'hFFFF_FFFF, 32'h0BAD_F00D, 1'b0);
		send_access(OP_LOAD, 32'h8000_0000, 32'h0, 1'b1);
		send_access(OP_LOAD, 32'h7FFF_FFFC, 32'h0, 1'b0);
	endtask

	task automatic test_register_extremes();
		drain_results();
		write_reg(CFG_ROW_DELAY, 17'd1023);
		write_reg(CFG_COLUMN_DELAY, 17'd1023);
		write_reg(CFG_MEM_LIMIT, 17'd65536);
		send_access(OP_LOAD, 32'h0000_0000, 32'h0, 1'b0);
		send_access(OP_STORE, 32'h0000_0400, 32'hA5A5_5A5A, 1'b0);
		drain_results();
		write_reg(CFG_ROW_DELAY, 17'd0);
		write_reg(CFG_COLUMN_DELAY, 17'd0);
		write_reg(CFG_MEM_LIMIT, 17'd0);
		send_access(OP_LOAD, 32'h0000_0000, 32'h0, 1'b0);
		send_access(OP_STORE, 32'hFFFF_FFFD, 32'h1111_1111, 1'b0);
		send_access(OP_LOAD, 32'h0000_0004, 32'h0, 1'b0);
		drain_results();
		write_reg(CFG_ROW_DELAY, 17'd5);
		write_reg(CFG_MEM_LIMIT, 17'd1026);
		send_access(OP_LOAD, 32'h0000_0400, 32'h0, 1'b0);
		send_access(OP_LOAD, 32'h0000_0401, 32'h0, 1'b0);
		send_access(OP_LOAD, 32'h0000_0404, 32'h0, 1'b0);
	endtask

	task automatic test_random_traffic(input int phases, input int items_per_phase);
		int unsigned span;
		int unsigned top_row;
		logic [LIMIT_W-1:0] limit;
		for (int p = 0; p < phases; p++) begin
			drain_results();
			case (p == 0 ? 0 : $urandom_range(0, 2))
				0: limit = 17'd65536;
				1: limit = LIMIT_W'($urandom_range(0, 65536));
				default: limit = LIMIT_W'($urandom_range(1024, 8192));
			endcase
			write_reg(CFG_ROW_DELAY, {7'd0, pick_delay()});
			write_reg(CFG_COLUMN_DELAY, {7'd0, pick_delay()});
			write_reg(CFG_MEM_LIMIT, limit);
			span = (limit > MEM_BYTES) ? MEM_BYTES : limit;
			top_row = (span == 0) ? 0 : (span - 1) / ROW_BYTES;
			foreach (hot_rows[i]) begin
				hot_rows[i] = $urandom_range(0, top_row);
			end
			for (int i = 0; i < items_per_phase; i++) begin
				if (i == items_per_phase / 2) begin
					drain_results();
				end
				send_access(1'($urandom_range(0, 1)), pick_address(span), $urandom,
					(i % 120) >= 40);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		access_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t ns: result with no item outstanding", $time);
			end else begin
				want = pending_results.pop_front();
				compare_field("load_data", want.load_data, load_data);
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("access_kind", 32'(want.kind), 32'(access_kind));
				compare_field("latency_cycles", 32'(want.latency), 32'(latency_cycles));
				compare_field("writeback_row", 32'(want.wb_row), 32'(writeback_row));
				compare_field("buffer_updates", want.updates, buffer_updates);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		foreach (word_mem[i]) begin
			word_mem[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_default_timing();
		test_register_extremes();
		test_random_traffic(6, 235);
		drain_results();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
